@@ hw/rtl/tet_pkg.sv @@
// Shared types and constants for the token expiry table.
// Used by the channel interfaces, the cell row, the response stage and the top level.
package tet_pkg;

   localparam int unsigned KEY_W  = 32;
   localparam int unsigned TIME_W = 31;
   localparam int unsigned EXP_W  = 32;
   localparam int unsigned CNT_W  = 7;
   localparam int unsigned MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_GENERATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RENEW    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   // operation broadcast to every cell while a wave walks the row
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  token_key;
      logic [TIME_W-1:0] now_time;
      logic [EXP_W-1:0]  new_exp;
   } op_type;

   // wave handed from cell to cell, one cell per cycle
   typedef struct packed {
      logic             act;
      logic             found;
      logic [CNT_W-1:0] cnt;
   } wave_type;

   typedef struct packed {
      logic [CNT_W-1:0] valid_count;
      logic             renewed;
      logic             dropped_valid;
   } rsp_word_type;

endpackage

@@ hw/rtl/tet_if.sv @@
// Valid/ready channel interfaces for the token expiry table request and response words.
// Depends on tet_pkg for field widths.
interface tet_req_if;
   import tet_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [KEY_W-1:0]    token_key;
   logic [TIME_W-1:0]   now_time;
   modport source (output valid, output mode, output token_key, output now_time, input ready);
   modport sink (input valid, input mode, input token_key, input now_time, output ready);
endinterface

interface tet_rsp_if;
   import tet_pkg::*;
   logic               valid;
   logic               ready;
   logic [CNT_W-1:0]   valid_count;
   logic               renewed;
   logic               dropped_valid;
   modport source (output valid, output valid_count, output renewed, output dropped_valid,
                   input ready);
   modport sink (input valid, input valid_count, input renewed, input dropped_valid,
                 output ready);
endinterface

@@ hw/rtl/tet_cell.sv @@
// One table cell: key and expiry registers plus the wave register fed by its neighbor.
// Depends on tet_pkg for op_type and wave_type.
module tet_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [tet_pkg::KEY_W-1:0]   shift_key_in,
   input  logic [tet_pkg::EXP_W-1:0]   shift_exp_in,
   output logic [tet_pkg::KEY_W-1:0]   key_out,
   output logic [tet_pkg::EXP_W-1:0]   exp_out,
   input  tet_pkg::op_type             op,
   input  tet_pkg::wave_type           wave_in,
   output tet_pkg::wave_type           wave_out
);
   import tet_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   wave_type         wave_ff;
   logic             live;
   logic             hit;

   assign live = exp_ff > {1'b0, op.now_time};
   // first unexpired match seen by the wave is the newest one
   assign hit  = wave_ff.act && (op.mode == MODE_RENEW) && !wave_ff.found &&
                 (key_ff == op.token_key) && live;

   always_comb begin
      key_in = key_ff;
      exp_in = exp_ff;
      if (shift_en) begin
         key_in = shift_key_in;
         exp_in = shift_exp_in;
      end else if (hit) begin
         exp_in = op.new_exp;
      end
   end

   always_comb begin
      wave_out.act   = wave_ff.act;
      wave_out.found = wave_ff.found | hit;
      wave_out.cnt   = wave_ff.cnt;
      if (wave_ff.act && (op.mode == MODE_COUNT) && live && (wave_ff.cnt != CNT_MAX)) begin
         wave_out.cnt = wave_ff.cnt + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= '0;
         key_ff  <= '0;
         wave_ff <= '0;
      end else begin
         exp_ff  <= exp_in;
         key_ff  <= key_in;
         wave_ff <= wave_in;
      end
   end

   assign key_out = key_ff;
   assign exp_out = exp_ff;

endmodule

@@ hw/rtl/tet_rsp_stage.sv @@
// Response output register with one hold slot behind it.
// Depends on tet_pkg for rsp_word_type and on tet_rsp_if.
module tet_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  done_valid,
   input  tet_pkg::rsp_word_type done_word,
   output logic                  hold_free,
   tet_rsp_if.source             rsp_port
);
   import tet_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         hold_valid_ff, hold_valid_in;
   rsp_word_type hold_word_ff, hold_word_in;
   logic         take;

   assign take = rsp_valid_ff && rsp_port.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      if (done_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = done_word;
         end else begin
            // output still waiting: park the word
            hold_valid_in = 1'b1;
            hold_word_in  = done_word;
         end
      end else if (take) begin
         rsp_valid_in  = hold_valid_ff;
         rsp_word_in   = hold_word_ff;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      rsp_word_ff  <= rsp_word_in;
      hold_word_ff <= hold_word_in;
   end

   assign hold_free              = !hold_valid_ff;
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.valid_count   = rsp_word_ff.valid_count;
   assign rsp_port.renewed       = rsp_word_ff.renewed;
   assign rsp_port.dropped_valid = rsp_word_ff.dropped_valid;

   a_hold_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("hold slot full while output register empty");

   a_no_done_into_full_hold: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !done_valid)
      else $error("finished word arrived with hold slot full");

endmodule

@@ hw/rtl/token_expiry_table.sv @@
// Token expiry table top level: request decode, row of cells, response stage.
// Depends on tet_pkg, tet_if, tet_cell and tet_rsp_stage.
//
//   port        dir    handshake            word
//   req_port    in     valid/ready          mode, token_key, now_time
//   rsp_port    out    valid/ready          valid_count, renewed, dropped_valid
//   csr_*       in     csr_wr_en            csr_wr_data = lifetime
//
// Generate and the unused mode answer at the accepting edge; for generate the row shifts there too.
// Renew and count send a wave that walks the cell row one cell a cycle.
// One request is in flight at a time; the next is taken while its response still waits,
// as long as the hold slot behind the output register is free.
// Reset is synchronous: it clears every expiry, sets lifetime to 1; no clearing pass.
module token_expiry_table #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   tet_req_if.sink                      req_port,
   tet_rsp_if.source                    rsp_port,
   input  logic                         csr_wr_en,
   input  logic [tet_pkg::TIME_W-1:0]   csr_wr_data
);
   import tet_pkg::*;

   logic [TIME_W-1:0] lifetime_ff;
   logic              busy_ff, busy_in;
   op_type            op_ff;
   logic [EXP_W-1:0]  new_exp_c;
   logic              accept, start, shift_en, immediate;
   logic              hold_free;
   logic              done_valid;
   rsp_word_type      done_word;

   logic [KEY_W-1:0]  key_chain [TABLE_DEPTH];
   logic [EXP_W-1:0]  exp_chain [TABLE_DEPTH];
   wave_type          wave_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] act_vec;

   assign req_port.ready = !busy_ff && hold_free;
   assign accept    = req_port.valid && req_port.ready;
   assign start     = accept && ((req_port.mode == MODE_RENEW) ||
                                 (req_port.mode == MODE_COUNT));
   assign shift_en  = accept && (req_port.mode == MODE_GENERATE);
   assign immediate = accept && !start;
   assign new_exp_c = {1'b0, req_port.now_time} + {1'b0, lifetime_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= {{(TIME_W-1){1'b0}}, 1'b1};
      end else if (csr_wr_en) begin
         lifetime_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff.mode      <= req_port.mode;
         op_ff.token_key <= req_port.token_key;
         op_ff.now_time  <= req_port.now_time;
         op_ff.new_exp   <= new_exp_c;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (wave_chain[TABLE_DEPTH].act) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // launch the wave into the newest cell
   assign wave_chain[0] = '{act: start, found: 1'b0, cnt: '0};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] shift_key;
      logic [EXP_W-1:0] shift_exp;
      if (i == 0) begin : g_head
         assign shift_key = req_port.token_key;
         assign shift_exp = new_exp_c;
      end else begin : g_body
         assign shift_key = key_chain[i-1];
         assign shift_exp = exp_chain[i-1];
      end
      tet_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .shift_en     (shift_en),
         .shift_key_in (shift_key),
         .shift_exp_in (shift_exp),
         .key_out      (key_chain[i]),
         .exp_out      (exp_chain[i]),
         .op           (op_ff),
         .wave_in      (wave_chain[i]),
         .wave_out     (wave_chain[i+1])
      );
      assign act_vec[i] = wave_chain[i+1].act;
   end

   always_comb begin
      done_valid = wave_chain[TABLE_DEPTH].act || immediate;
      done_word  = '0;
      if (wave_chain[TABLE_DEPTH].act) begin
         done_word.valid_count = wave_chain[TABLE_DEPTH].cnt;
         done_word.renewed     = wave_chain[TABLE_DEPTH].found;
      end else if (shift_en) begin
         done_word.dropped_valid = exp_chain[TABLE_DEPTH-1] > {1'b0, req_port.now_time};
      end
   end

   tet_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .done_valid (done_valid),
      .done_word  (done_word),
      .hold_free  (hold_free),
      .rsp_port   (rsp_port)
   );

   a_start_enters_head: assert property (@(posedge clock) disable iff (reset)
      start |=> act_vec[0])
      else $error("wave did not enter the newest cell");

   a_single_wave: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one wave in the row");

   a_idle_no_wave: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (act_vec == '0))
      else $error("wave in the row while idle");

   a_wave_end_busy: assert property (@(posedge clock) disable iff (reset)
      wave_chain[TABLE_DEPTH].act |-> (busy_ff && !req_port.ready))
      else $error("wave finished outside a busy operation");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for token_expiry_table: directed and random words, per-field checks.
// Depends on tet_pkg and the tet_req_if / tet_rsp_if channel interfaces.
`timescale 1ns / 1ps

module testbench;
   import tet_pkg::*;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;
   localparam int unsigned REPORT_LIMIT = 100;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  token_key;
      logic [TIME_W-1:0] now_time;
   } req_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [TIME_W-1:0] csr_wr_data = '0;

   tet_req_if req_bus ();
   tet_rsp_if rsp_bus ();

   token_expiry_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // shadow of the table: cell 0 newest, last cell oldest
   logic [KEY_W-1:0]  key_row    [TABLE_DEPTH];
   logic [EXP_W-1:0]  expiry_row [TABLE_DEPTH];
   logic [TIME_W-1:0] lifetime_now;
   logic [KEY_W-1:0]  key_pool   [8];

   req_word_type request_queue [$];
   rsp_word_type pending_responses [$];
   req_word_type cur_req;
   bit           offering;
   int unsigned  burst_left;
   int unsigned  gap_left;
   int unsigned  error_count;
   logic [15:0]  stall_mask;
   logic [3:0]   stall_pos;
   int unsigned  stall_tick;

   function automatic rsp_word_type table_apply(req_word_type r);
      rsp_word_type res;
      logic [EXP_W-1:0] now_x;
      logic [EXP_W-1:0] fresh_exp;
      bit hit;
      res = '0;
      now_x = {1'b0, r.now_time};
      fresh_exp = now_x + {1'b0, lifetime_now};
      hit = 1'b0;
      case (r.mode)
         MODE_GENERATE: begin
            res.dropped_valid = expiry_row[TABLE_DEPTH-1] > now_x;
            for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
               key_row[i] = key_row[i-1];
               expiry_row[i] = expiry_row[i-1];
            end
            key_row[0] = r.token_key;
            expiry_row[0] = fresh_exp;
         end
         MODE_RENEW: begin
            // only the newest live match is refreshed
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!hit && key_row[i] == r.token_key && expiry_row[i] > now_x) begin
                  expiry_row[i] = fresh_exp;
                  hit = 1'b1;
               end
            end
            res.renewed = hit;
         end
         MODE_COUNT: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (expiry_row[i] > now_x && res.valid_count < CNT_MAX)
                  res.valid_count = res.valid_count + 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic push_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [TIME_W-1:0] now);
      req_word_type r;
      r.mode = mode;
      r.token_key = key;
      r.now_time = now;
      request_queue = {request_queue, r};
   endtask

   task automatic wait_idle();
      while (request_queue.size() != 0 || offering || pending_responses.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_lifetime(logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      lifetime_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // time walks forward from start_time so that entries age out as in real use
   task automatic run_phase(int unsigned n, int unsigned start_time, int unsigned step_max);
      int unsigned cursor;
      int unsigned pick;
      req_word_type r;
      cursor = start_time;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            r.mode = MODE_GENERATE;
         else if (pick < 70)
            r.mode = MODE_RENEW;
         else if (pick < 95)
            r.mode = MODE_COUNT;
         else
            r.mode = MODE_UNUSED;
         if ($urandom_range(0, 4) == 0)
            r.token_key = $urandom;
         else
            r.token_key = key_pool[$urandom_range(0, 7)];
         if ($urandom_range(0, 15) == 0)
            r.now_time = 31'($urandom);
         else
            r.now_time = cursor[TIME_W-1:0];
         request_queue = {request_queue, r};
         cursor = cursor + $urandom_range(0, step_max);
         if (cursor > 32'(TIME_MAX))
            cursor = 32'(TIME_MAX);
      end
      wait_idle();
   endtask

   // request driver: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_responses = {pending_responses, table_apply(cur_req)};
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (request_queue.size() != 0) begin
               cur_req = request_queue.pop_front();
               offering = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
         req_bus.valid <= offering;
         req_bus.mode <= cur_req.mode;
         req_bus.token_key <= cur_req.token_key;
         req_bus.now_time <= cur_req.now_time;
      end
   end

   // response monitor: check each word, stall on a rotating mask
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_responses.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("response word with none expected");
            end else begin
               automatic rsp_word_type want = pending_responses.pop_front();
               if (rsp_bus.valid_count !== want.valid_count) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $error("valid_count: expected %0d, actual %0d",
                            want.valid_count, rsp_bus.valid_count);
               end
               if (rsp_bus.renewed !== want.renewed) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $error("renewed: expected %0d, actual %0d", want.renewed, rsp_bus.renewed);
               end
               if (rsp_bus.dropped_valid !== want.dropped_valid) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $error("dropped_valid: expected %0d, actual %0d",
                            want.dropped_valid, rsp_bus.dropped_valid);
               end
            end
         end
         stall_tick++;
         if (stall_tick % 256 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_mask = '1;
               1: stall_mask = 16'h0001;
               default: stall_mask = 16'($urandom);
            endcase
         end
         stall_pos = stall_pos + 1'b1;
         rsp_bus.ready <= stall_mask[stall_pos];
      end
   end

   initial begin
      #4_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = '0;
      req_bus.token_key = '0;
      req_bus.now_time = '0;
      rsp_bus.ready = 1'b0;
      cur_req = '0;
      offering = 1'b0;
      error_count = 0;
      stall_mask = '1;
      stall_pos = '0;
      stall_tick = 0;
      lifetime_now = 31'd1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         key_row[i] = '0;
         expiry_row[i] = '0;
      end
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      for (int i = 2; i < 8; i++)
         key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, key zero against empty cells, unused mode, reset lifetime
      push_request(MODE_COUNT, '0, '0);
      push_request(MODE_RENEW, '0, '0);
      push_request(MODE_UNUSED, KEY_MAX, TIME_MAX);
      push_request(MODE_GENERATE, '0, '0);
      push_request(MODE_COUNT, '0, '0);
      push_request(MODE_RENEW, '0, '0);
      push_request(MODE_COUNT, '0, 31'd1);
      wait_idle();

      // widest expiry: largest time plus largest lifetime
      write_lifetime(TIME_MAX);
      push_request(MODE_GENERATE, KEY_MAX, TIME_MAX);
      push_request(MODE_COUNT, '0, TIME_MAX);
      push_request(MODE_RENEW, KEY_MAX, TIME_MAX);
      push_request(MODE_GENERATE, 32'hA5A5_A5A5, '0);
      push_request(MODE_RENEW, 32'h1234_5678, 31'd5);
      push_request(MODE_COUNT, KEY_MAX, '0);
      push_request(MODE_COUNT, '0, 31'h5555_5555);
      wait_idle();

      // zero lifetime: new and renewed entries expire at once
      write_lifetime('0);
      push_request(MODE_GENERATE, 32'h5A5A_5A5A, 31'd100);
      push_request(MODE_RENEW, 32'h5A5A_5A5A, 31'd100);
      push_request(MODE_COUNT, '0, 31'd99);
      push_request(MODE_COUNT, '0, 31'd100);
      push_request(MODE_RENEW, 32'hA5A5_A5A5, 31'h2AAA_AAAA);
      push_request(MODE_UNUSED, '0, '0);
      wait_idle();

      write_lifetime(31'd1);
      run_phase(80, 0, 1);
      write_lifetime(TIME_MAX);
      run_phase(100, $urandom_range(0, 32'h3FFF_FFFF), 100);
      write_lifetime(31'($urandom_range(20, 400)));
      run_phase(100, 32'(TIME_MAX) - 30000, 40);
      write_lifetime('0);
      run_phase(50, $urandom_range(0, 32'h7FFF_0000), 20);
      write_lifetime(31'($urandom));
      run_phase(100, $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(1, 32'h10_0000));
      write_lifetime(31'($urandom_range(50, 150)));
      run_phase(120, 0, 10);

      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/tet_pkg.sv
hw/rtl/tet_if.sv
hw/rtl/tet_cell.sv
hw/rtl/tet_rsp_stage.sv
hw/rtl/token_expiry_table.sv
dv/testbench.sv
